FILE: src/wide_unsigned_divider_defines.svh
// Assertion helpers for the wide unsigned divider.
// Each check samples on clk; WUD_ASSERT checks are off while rst_n is low, WUD_ASSERT_ALWAYS checks are not.
`ifndef WIDE_UNSIGNED_DIVIDER_DEFINES_SVH
`define WIDE_UNSIGNED_DIVIDER_DEFINES_SVH

// Implication check on the block clock.
`define WUD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that must also hold while reset is asserted.
`define WUD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wud_pkg.sv
`timescale 1ns / 1ps

package wud_pkg;

  localparam int WORD_W = 64;
  localparam int VAL_W  = 2 * WORD_W;
  localparam int DATA_W = 4 * WORD_W;
  localparam int CNT_W  = 7;

  // Bit index of the top bit of a word.
  localparam int WORD_MSB = 63;

  localparam logic [CNT_W-1:0] CNT_LAST  = 7'd127;
  localparam logic [CNT_W-1:0] CNT_ZERO  = 7'd0;
  localparam logic [CNT_W-1:0] CNT_ONE   = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

endpackage

FILE: src/wud_datapath.sv
`timescale 1ns / 1ps

module wud_datapath (
  input  logic                             clk,
  input  wud_pkg::ctrl_t                   ctrl,
  input  logic [wud_pkg::DATA_W-1:0]       in_word,
  output logic [wud_pkg::DATA_W-1:0]       res_word,
  output logic                             res_zero
);
  import wud_pkg::*;

  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] div_r, div_nxt;
  logic             zdiv_r, zdiv_nxt;

  logic [VAL_W:0]   shifted;
  logic [VAL_W+1:0] diff;
  logic             ge;

  // Shift in the next dividend bit; the 129-bit compare covers the bit that leaves.
  assign shifted = {rem_r, quo_r[VAL_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};
  assign ge      = ~diff[VAL_W+1];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    zdiv_nxt = zdiv_r;
    if (ctrl.load) begin
      rem_nxt  = '0;
      quo_nxt  = in_word[VAL_W-1:0];
      div_nxt  = in_word[DATA_W-1:VAL_W];
      zdiv_nxt = ~|in_word[DATA_W-1:VAL_W];
    end else if (ctrl.step) begin
      rem_nxt = ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
      quo_nxt = {quo_r[VAL_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    zdiv_r <= zdiv_nxt;
  end

  // Drop the result to zero on a zero divisor.
  assign res_word = zdiv_r ? '0 : {rem_r, quo_r};
  assign res_zero = zdiv_r;

endmodule

FILE: src/wud_ctrl.sv
`timescale 1ns / 1ps
`include "wide_unsigned_divider_defines.svh"

module wud_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_free,
  output logic           idle,
  output wud_pkg::ctrl_t ctrl
);
  import wud_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.load = 1'b1;
          cnt_nxt   = CNT_LAST;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        if (cnt_r == CNT_ZERO) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_ONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register can take the word.
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= CNT_ZERO;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

  `WUD_ASSERT(a_load_starts_run, ctrl.load |=> (state_r == ST_RUN && cnt_r == CNT_LAST), "load did not start a full run")
  `WUD_ASSERT(a_count_down, (state_r == ST_RUN && cnt_r != CNT_ZERO) |=> (state_r == ST_RUN && cnt_r == $past(cnt_r) - CNT_ONE), "step counter skipped")
  `WUD_ASSERT(a_run_ends, (state_r == ST_RUN && cnt_r == CNT_ZERO) |=> (state_r == ST_DONE), "run did not end after last step")
  `WUD_ASSERT(a_finish_idle, ctrl.finish |=> idle, "finish did not return to idle")
  `WUD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> idle, "reset did not clear sequencer")

endmodule

FILE: src/wide_unsigned_divider.sv
// 128-bit unsigned divider, restoring long division, one quotient bit per cycle.
// From input accept to out_tvalid: load, 128 steps, then a finish that registers the result once the output is free.
// A new word is accepted only once the sequencer is idle again; the single subtract unit serves one word at a time.
// The output register lets the next word enter while a result waits.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid.
`timescale 1ns / 1ps

module wide_unsigned_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // dividend_low, dividend_high, divisor_low, divisor_high
  input  logic [wud_pkg::DATA_W-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // quotient_low, quotient_high, remainder_low, remainder_high
  output logic [wud_pkg::DATA_W-1:0] out_tdata,
  // zero_divisor
  output logic [0:0]                 out_tuser
);
  import wud_pkg::*;

  ctrl_t             ctrl;
  logic              idle;
  logic              in_fire;
  logic              out_free;
  logic [DATA_W-1:0] res_word;
  logic              res_zero;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              out_zero_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid & idle;
  assign out_free  = ~out_valid_r | out_tready;

  wud_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  wud_datapath u_datapath (
    .clk      (clk),
    .ctrl     (ctrl),
    .in_word  (in_tdata),
    .res_word (res_word),
    .res_zero (res_zero)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_data_r <= res_word;
      out_zero_r <= res_zero;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

endmodule

FILE: tb/tb_wide_unsigned_divider.sv
`timescale 1ns / 1ps

module tb_wide_unsigned_divider;
  import wud_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 930;
  localparam int DRAIN_CYCLES   = 140;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [0:0]        out_tuser;

  // Steady stretch: neither side idles.
  bit steady = 1'b0;

  typedef struct packed {
    logic              zero_div;
    logic [WORD_W-1:0] rem_hi;
    logic [WORD_W-1:0] rem_lo;
    logic [WORD_W-1:0] quo_hi;
    logic [WORD_W-1:0] quo_lo;
  } quo_rem_t;

  class quotient_scoreboard;
    quo_rem_t pending_results[$];
    int       errors = 0;

    function quo_rem_t restoring_divide(logic [VAL_W-1:0] num, logic [VAL_W-1:0] den);
      quo_rem_t        res;
      logic [VAL_W:0]  part;
      logic [VAL_W-1:0] quo;
      res  = '0;
      part = '0;
      quo  = '0;
      if (den == '0) begin
        res.zero_div = 1'b1;
        return res;
      end
      // One quotient bit per step, top bit first; the extra bit keeps the shifted-out carry.
      for (int i = VAL_W - 1; i >= 0; i--) begin
        part = {part[VAL_W-1:0], num[i]};
        if (part >= {1'b0, den}) begin
          part   = part - {1'b0, den};
          quo[i] = 1'b1;
        end
      end
      res.quo_lo = quo[WORD_W-1:0];
      res.quo_hi = quo[VAL_W-1:WORD_W];
      res.rem_lo = part[WORD_W-1:0];
      res.rem_hi = part[VAL_W-1:WORD_W];
      return res;
    endfunction

    function void note_operands(logic [DATA_W-1:0] word);
      pending_results.push_back(restoring_divide(word[VAL_W-1:0], word[DATA_W-1:VAL_W]));
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic zero_flag);
      quo_rem_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h / %b",
                 $time, data, zero_flag);
        return;
      end
      exp = pending_results.pop_front();
      compare_field("quotient_low", exp.quo_lo, data[WORD_W-1:0]);
      compare_field("quotient_high", exp.quo_hi, data[2*WORD_W-1:WORD_W]);
      compare_field("remainder_low", exp.rem_lo, data[3*WORD_W-1:2*WORD_W]);
      compare_field("remainder_high", exp.rem_hi, data[4*WORD_W-1:3*WORD_W]);
      compare_field("zero_divisor", {{(WORD_W-1){1'b0}}, exp.zero_div},
                    {{(WORD_W-1){1'b0}}, zero_flag});
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  quotient_scoreboard sb = new();

  wide_unsigned_divider dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Random value with exactly nbits significant bits (0 gives zero).
  function logic [VAL_W-1:0] rand_bits(int nbits);
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] mask;
    v = {$urandom, $urandom, $urandom, $urandom};
    if (nbits == 0) return '0;
    mask = ({{(VAL_W-1){1'b0}}, 1'b1} << nbits) - 1'b1;
    v    = v & mask;
    v[nbits-1] = 1'b1;
    return v;
  endfunction

  task send_operands(input logic [VAL_W-1:0] num, input logic [VAL_W-1:0] den);
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {den, num};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_operands({den, num});
  endtask

  task send_random;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
    int               pick;
    int               nlen;
    pick = $urandom_range(0, 99);
    nlen = $urandom_range(0, VAL_W);
    num  = rand_bits(nlen);
    if (pick < 4) begin
      den = '0;
    end else if (pick < 10) begin
      den = 128'd2;
    end else if (pick < 15) begin
      den = (num == '0) ? rand_bits($urandom_range(1, VAL_W)) : num;
      num = den;
    end else if (pick < 25) begin
      den = rand_bits($urandom_range((nlen < VAL_W) ? nlen + 1 : VAL_W, VAL_W));
    end else if (pick < 35) begin
      num = rand_bits(VAL_W) ^ {$urandom, $urandom, $urandom, $urandom};
      den = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      if (nlen == 0) begin
        nlen = $urandom_range(1, VAL_W);
        num  = rand_bits(nlen);
      end
      den = rand_bits($urandom_range(1, nlen));
    end
    send_operands(num, den);
  endtask

  // Result side: random idling, an occasional long hold so the next word finishes
  // while a result waits, and the check of every accepted word.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        sb.check_result(out_tdata, out_tuser[0]);
        if (!steady && $urandom_range(0, 24) == 0) stall_left = $urandom_range(140, 260);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
          idle_cycles = 0;
        else
          idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("wide_unsigned_divider test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] ones;
    logic [VAL_W-1:0] top;
    ones = '1;
    top  = {1'b1, {(VAL_W-1){1'b0}}};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero divisor
    send_operands(ones, '0);
    send_operands('0, '0);
    // divisor of two, including odd dividends and the all-ones extreme
    send_operands(ones, 128'd2);
    send_operands(128'd3, 128'd2);
    send_operands('0, 128'd2);
    send_operands(128'd1, 128'd2);
    send_operands(128'd2, 128'd2);
    // dividend equal to divisor
    send_operands(ones, ones);
    send_operands(128'd1, 128'd1);
    send_operands(top, top);
    // dividend below divisor
    send_operands(128'd5, ones);
    send_operands('0, 128'd1);
    send_operands(top - 1'b1, top);
    // general cases at the extremes
    send_operands(ones, 128'd1);
    send_operands(ones, top);
    send_operands(ones, top + 1'b1);
    send_operands(ones, {64'd1, 64'd0});
    send_operands({64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 128'd3);
    send_operands({64'd1, 64'd0}, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operands(top, top - 1'b1);
    send_operands(ones, 128'd7);
    send_operands(ones ^ top, ones >> 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 550);
      send_random();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("wide_unsigned_divider test passed");
    else
      $display("wide_unsigned_divider test failed");
    $finish;
  end

endmodule

FILE: wide_unsigned_divider.f
+incdir+src
src/wud_pkg.sv
src/wud_datapath.sv
src/wud_ctrl.sv
src/wide_unsigned_divider.sv
tb/tb_wide_unsigned_divider.sv
